// ----- rtl/core/ostq_pkg.sv -----
// ----------------------------------------------------------------------------
// ostq_pkg
// Shared constants and types of the one-shot timer queue.
// ----------------------------------------------------------------------------
package ostq_pkg;

	localparam int TABLE_DEPTH   = 16;
	localparam int CHANNEL_COUNT = 64;
	localparam int IDX_W         = $clog2(TABLE_DEPTH);
	localparam int CH_W          = 6;
	localparam int Q_DEPTH       = 2;
	localparam int QP_W          = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int QC_W          = $clog2(Q_DEPTH + 1);

	localparam logic [19:0] NS_PER_MS = 20'd1000000;

	localparam logic [1:0] OP_OPEN   = 2'd0;
	localparam logic [1:0] OP_ARM    = 2'd1;
	localparam logic [1:0] OP_CANCEL = 2'd2;
	localparam logic [1:0] OP_TICK   = 2'd3;

	localparam logic [1:0] K_EXPIRY  = 2'd0;
	localparam logic [1:0] K_SUMMARY = 2'd1;
	localparam logic [1:0] K_REJECT  = 2'd2;

	typedef struct packed {
		logic [1:0]      opcode;
		logic [CH_W-1:0] channel;
		logic [31:0]     delay_ms;
		logic [63:0]     now_ns;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} q_head_t;

endpackage

// ----- rtl/core/ostq_front.sv -----
// ----------------------------------------------------------------------------
// ostq_front
// Command intake: accepts beats and holds them in a short queue for the back.
// ----------------------------------------------------------------------------
module ostq_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  ostq_pkg::item_t          item,
	output logic                     busy,
	output ostq_pkg::q_head_t        head,
	input  logic                     pop
);
	import ostq_pkg::*;

	item_t            mem_q [Q_DEPTH];
	logic [QP_W-1:0]  wr_q;
	logic [QP_W-1:0]  rd_q;
	logic [QC_W-1:0]  cnt_q;
	logic             push;
	logic             do_pop;

	assign busy   = (cnt_q == QC_W'(Q_DEPTH));
	assign push   = start && !busy;
	assign do_pop = pop && (cnt_q != '0);

	assign head.valid = (cnt_q != '0);
	assign head.item  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QP_W'(Q_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == QP_W'(Q_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + QC_W'(push) - QC_W'(do_pop);
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QC_W'(Q_DEPTH)) else $error("queue overfilled");
	a_full_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !push) else $error("push while full");
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !do_pop) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count slip");

endmodule

// ----- rtl/core/ostq_back.sv -----
// ----------------------------------------------------------------------------
// ostq_back
// Timer table and sequencer: open, arm, cancel, deadline-ordered scan, expiry and summary.
// ----------------------------------------------------------------------------
module ostq_back (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ostq_pkg::q_head_t        head,
	output logic                     pop,
	output logic                     strobe,
	output logic [1:0]               kind,
	output logic [ostq_pkg::CH_W-1:0] event_channel,
	output logic [44:0]              elapsed_ms,
	output logic [63:0]              wait_ns,
	output logic                     use_default_timeout,
	output logic                     last
);
	import ostq_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EXEC = 3'd1;
	localparam logic [2:0] S_MUL  = 3'd2;
	localparam logic [2:0] S_ARM  = 3'd3;
	localparam logic [2:0] S_SCAN = 3'd4;
	localparam logic [2:0] S_EVAL = 3'd5;
	localparam logic [2:0] S_DIV  = 3'd6;
	localparam logic [2:0] S_EXP  = 3'd7;

	// floor(2^64 / 1e6)
	localparam logic [44:0] MS_RECIP = 45'd18446744073709;

	logic [2:0]              state_q;
	item_t                   it_q;
	logic                    cancel_q;
	logic [51:0]             span_q;
	logic [IDX_W-1:0]        idx_q;
	logic                    have_q;
	logic [IDX_W-1:0]        bslot_q;
	logic [63:0]             bdl_q;
	logic [63:0]             bst_q;
	logic [CH_W-1:0]         bown_q;
	logic [63:0]             dvd_q;
	logic [44:0]             quot_q;
	logic [109:0]            acc_q;
	logic [63:0]             prod_q;
	logic [2:0]              cnt_q;

	logic [63:0]             dl_mem  [TABLE_DEPTH];
	logic [63:0]             st_mem  [TABLE_DEPTH];
	logic [CH_W-1:0]         own_mem [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0]  valid_q;
	logic [CHANNEL_COUNT-1:0] open_q;

	logic                    strobe_q;
	logic [1:0]              kind_q;
	logic [CH_W-1:0]         evch_q;
	logic [44:0]             el_q;
	logic [63:0]             wait_q;
	logic                    dflt_q;
	logic                    last_q;

	logic                    free_any;
	logic [IDX_W-1:0]        free_idx;
	logic [64:0]             dl_sum;
	logic [63:0]             dl_new;
	logic                    arm_wr;
	logic                    cand;
	logic                    better;
	logic [31:0]             mac_a;
	logic [31:0]             mac_b;
	logic [63:0]             mac_p;
	logic [109:0]            mac_sh;
	logic [63:0]             rem_w;

	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_any = 1'b1;
				free_idx = IDX_W'(i);
			end
		end
	end

	// saturating deadline
	assign dl_sum = {1'b0, it_q.now_ns} + {13'd0, span_q};
	assign dl_new = dl_sum[64] ? '1 : dl_sum[63:0];
	assign arm_wr = (state_q == S_ARM) && free_any;

	assign cand   = valid_q[idx_q] && (!cancel_q || own_mem[idx_q] == it_q.channel);
	assign better = !have_q || (dl_mem[idx_q] < bdl_q) ||
		((dl_mem[idx_q] == bdl_q) && (st_mem[idx_q] < bst_q));

	// elapsed / 1e6 by reciprocal multiply, one 32x32 partial product a cycle
	always_comb begin
		unique case (cnt_q)
			3'd0: begin
				mac_a = dvd_q[31:0];
				mac_b = MS_RECIP[31:0];
			end
			3'd1: begin
				mac_a = dvd_q[31:0];
				mac_b = {19'd0, MS_RECIP[44:32]};
			end
			3'd2: begin
				mac_a = dvd_q[63:32];
				mac_b = MS_RECIP[31:0];
			end
			default: begin
				mac_a = dvd_q[63:32];
				mac_b = {19'd0, MS_RECIP[44:32]};
			end
		endcase
	end

	assign mac_p = {32'd0, mac_a} * {32'd0, mac_b};

	always_comb begin
		unique case (cnt_q)
			3'd0:       mac_sh = {46'd0, mac_p};
			3'd1, 3'd2: mac_sh = {14'd0, mac_p, 32'd0};
			default:    mac_sh = {mac_p[45:0], 64'd0};
		endcase
	end

	// estimate is the quotient or one below it
	assign rem_w = dvd_q - prod_q;

	assign pop = (state_q == S_IDLE) && head.valid;

	always_ff @(posedge clk) begin
		if (arm_wr) begin
			dl_mem[free_idx]  <= dl_new;
			st_mem[free_idx]  <= it_q.now_ns;
			own_mem[free_idx] <= it_q.channel;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (pop) begin
			it_q <= head.item;
		end
		if (state_q == S_MUL) begin
			span_q <= it_q.delay_ms * NS_PER_MS;
		end
		if (state_q == S_SCAN && cand && better) begin
			bslot_q <= idx_q;
			bdl_q   <= dl_mem[idx_q];
			bst_q   <= st_mem[idx_q];
			bown_q  <= own_mem[idx_q];
		end
		if (state_q == S_EVAL) begin
			dvd_q <= it_q.now_ns - bst_q;
		end else if (state_q == S_DIV) begin
			priority if (cnt_q == 3'd0) begin
				acc_q <= mac_sh;
			end else if (cnt_q <= 3'd3) begin
				acc_q <= acc_q + mac_sh;
			end else if (cnt_q == 3'd4) begin
				quot_q <= acc_q[108:64];
			end else if (cnt_q == 3'd5) begin
				prod_q <= {19'd0, quot_q} * {44'd0, NS_PER_MS};
			end else if (rem_w >= {44'd0, NS_PER_MS}) begin
				quot_q <= quot_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cancel_q <= 1'b0;
			idx_q    <= '0;
			have_q   <= 1'b0;
			cnt_q    <= '0;
			valid_q  <= '0;
			open_q   <= '0;
			strobe_q <= 1'b0;
			kind_q   <= K_EXPIRY;
			evch_q   <= '0;
			el_q     <= '0;
			wait_q   <= '0;
			dflt_q   <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (head.valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					idx_q  <= '0;
					have_q <= 1'b0;
					unique case (it_q.opcode)
						OP_OPEN: begin
							open_q[it_q.channel] <= 1'b1;
							state_q <= S_IDLE;
						end
						OP_ARM: begin
							state_q <= open_q[it_q.channel] ? S_MUL : S_IDLE;
						end
						OP_CANCEL: begin
							cancel_q <= 1'b1;
							state_q  <= S_SCAN;
						end
						default: begin
							cancel_q <= 1'b0;
							state_q  <= S_SCAN;
						end
					endcase
				end
				S_MUL: begin
					state_q <= S_ARM;
				end
				S_ARM: begin
					if (free_any) begin
						valid_q[free_idx] <= 1'b1;
					end else begin
						strobe_q <= 1'b1;
						kind_q   <= K_REJECT;
						evch_q   <= it_q.channel;
						el_q     <= '0;
						wait_q   <= '0;
						dflt_q   <= 1'b0;
						last_q   <= 1'b0;
					end
					cancel_q <= 1'b0;
					idx_q    <= '0;
					have_q   <= 1'b0;
					state_q  <= S_SCAN;
				end
				S_SCAN: begin
					if (cand && better) begin
						have_q <= 1'b1;
					end
					if (idx_q == IDX_W'(TABLE_DEPTH - 1)) begin
						state_q <= S_EVAL;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_EVAL: begin
					idx_q  <= '0;
					have_q <= 1'b0;
					cnt_q  <= '0;
					priority if (cancel_q) begin
						if (have_q) begin
							valid_q[bslot_q]     <= 1'b0;
							open_q[it_q.channel] <= 1'b0;
						end
						state_q <= S_IDLE;
					end else if (have_q && it_q.now_ns >= bdl_q) begin
						valid_q[bslot_q] <= 1'b0;
						state_q <= open_q[bown_q] ? S_DIV : S_SCAN;
					end else begin
						strobe_q <= 1'b1;
						kind_q   <= K_SUMMARY;
						evch_q   <= '0;
						el_q     <= '0;
						wait_q   <= have_q ? bdl_q - it_q.now_ns : '0;
						dflt_q   <= !have_q;
						last_q   <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 3'd6) begin
						state_q <= S_EXP;
					end
				end
				default: begin
					strobe_q <= 1'b1;
					kind_q   <= K_EXPIRY;
					evch_q   <= bown_q;
					el_q     <= quot_q;
					wait_q   <= '0;
					dflt_q   <= 1'b0;
					last_q   <= 1'b0;
					state_q  <= S_SCAN;
				end
			endcase
		end
	end

	assign strobe              = strobe_q;
	assign kind                = kind_q;
	assign event_channel       = evch_q;
	assign elapsed_ms          = el_q;
	assign wait_ns             = wait_q;
	assign use_default_timeout = dflt_q;
	assign last                = last_q;

	a_last_summary: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (last == (kind == K_SUMMARY))) else $error("last flag mismatch");
	a_dflt_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && use_default_timeout) |-> (wait_ns == '0 && kind == K_SUMMARY))
		else $error("default timeout with wait");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> state_q == S_EXEC) else $error("pop outside idle");
	a_retire: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EVAL && !cancel_q && have_q && it_q.now_ns >= bdl_q)
		|=> !valid_q[$past(bslot_q)]) else $error("due entry not retired");

endmodule

// ----- rtl/core/one_shot_timer_queue.sv -----
// ----------------------------------------------------------------------------
// one_shot_timer_queue
// Table of sixteen one-shot timers over sixty-four channels.
// ----------------------------------------------------------------------------
// A command beat (opcode, channel, delay_ms, now_ns) is taken when start is
// high and busy is low. Up to two beats wait in the intake queue; busy rises
// only when that queue is full, so the sender can run ahead of the table.
// Results appear with strobe high and cannot be held off; the last result
// of an arm or tick is the summary, flagged by last.
// Work per beat, set by the sequencer in the back part: open and a
// closed-channel arm give no result; cancel makes one pass over the table.
// tick makes a table pass per retired entry and one more, and each expiry
// beat takes its elapsed time from a four-step reciprocal multiply for the
// divide by 1e6 and one correction step. arm adds the multiply and the
// table write. A tick with nothing due gives only its summary.
// Reset clears the queue, all valid bits and all open-channel bits at once;
// timer payload is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
module one_shot_timer_queue (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [1:0]                 opcode,
	input  logic [ostq_pkg::CH_W-1:0]  channel,
	input  logic [31:0]                delay_ms,
	input  logic [63:0]                now_ns,
	output logic                       strobe,
	output logic [1:0]                 kind,
	output logic [ostq_pkg::CH_W-1:0]  event_channel,
	output logic [44:0]                elapsed_ms,
	output logic [63:0]                wait_ns,
	output logic                       use_default_timeout,
	output logic                       last
);
	import ostq_pkg::*;

	item_t   item;
	q_head_t head;
	logic    pop;

	assign item.opcode   = opcode;
	assign item.channel  = channel;
	assign item.delay_ms = delay_ms;
	assign item.now_ns   = now_ns;

	ostq_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.head   (head),
		.pop    (pop)
	);

	ostq_back u_back (
		.clk                 (clk),
		.arst_n              (arst_n),
		.head                (head),
		.pop                 (pop),
		.strobe              (strobe),
		.kind                (kind),
		.event_channel       (event_channel),
		.elapsed_ms          (elapsed_ms),
		.wait_ns             (wait_ns),
		.use_default_timeout (use_default_timeout),
		.last                (last)
	);

endmodule
